// ===== rtl/core/rdrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive descriptor ring producer - shared package
// Payload types, field widths, status codes, FSM states and parameter defaults.
// ----------------------------------------------------------------------------
package rdrp_pkg;

   // Field widths
   localparam int ENTRY_W = 10;
   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 14;
   localparam int WORD_W  = 32;

   // Parameter defaults
   localparam int ENTRY_COUNT_DEF  = 1024;
   localparam int COPY_LIMIT_DEF   = 2048;
   localparam int PACKET_LIMIT_DEF = 16383;

   // Command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_REFILL  = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Input request
   typedef struct packed {
      logic               cmd;
      logic [ENTRY_W-1:0] entry_index;
      logic [ADDR_W-1:0]  dest_address;
      logic [ADDR_W-1:0]  source_address;
      logic [LEN_W-1:0]   pkt_len;
      logic [LEN_W-1:0]   frag_len;
      logic               flag_bit;
      logic [5:0]         rx_flags;
      logic [4:0]         route;
      logic [15:0]        flow_tag;
      logic [WORD_W-1:0]  pkt_word;
   } req_type;

   // Result
   typedef struct packed {
      status_type         status;
      logic               copy_valid;
      logic [ADDR_W-1:0]  copy_source;
      logic [ADDR_W-1:0]  copy_dest;
      logic [LEN_W-1:0]   copy_bytes;
      logic               oversize_used;
      logic [ENTRY_W-1:0] written_entry;
      logic [WORD_W-1:0]  control_word;
      logic [WORD_W-1:0]  metadata_word;
      logic [WORD_W-1:0]  desc_word;
      logic [ENTRY_W-1:0] next_producer;
   } rsp_type;

   // Store updates decided by the execute logic
   typedef struct packed {
      logic refill_wr;   // write dest address and clear occupied mark
      logic commit;      // mark producer entry occupied and advance
   } exec_ctl_type;

endpackage

// ===== rtl/core/rdrp_ring_mem.sv =====
// ----------------------------------------------------------------------------
// Receive descriptor ring producer - ring entry stores
// Occupied marks and destination addresses, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module rdrp_ring_mem #(
   parameter int ENTRY_COUNT = rdrp_pkg::ENTRY_COUNT_DEF,
   localparam int IDX_W      = $clog2(ENTRY_COUNT)
) (
   input  logic                      clock,
   input  logic                      occ_wr_en,
   input  logic [IDX_W-1:0]          occ_wr_addr,
   input  logic                      occ_wr_data,
   input  logic [IDX_W-1:0]          occ_rd_addr,
   output logic                      occ_rd_data,
   input  logic                      dest_wr_en,
   input  logic [IDX_W-1:0]          dest_wr_addr,
   input  logic [rdrp_pkg::ADDR_W-1:0] dest_wr_data,
   input  logic [IDX_W-1:0]          dest_rd_addr,
   output logic [rdrp_pkg::ADDR_W-1:0] dest_rd_data
);
   import rdrp_pkg::*;

   logic              occ_mem  [ENTRY_COUNT];
   logic [ADDR_W-1:0] dest_mem [ENTRY_COUNT];

   // Occupied marks
   always_ff @(posedge clock) begin
      if (occ_wr_en) begin
         occ_mem[occ_wr_addr] <= occ_wr_data;
      end
      occ_rd_data <= occ_mem[occ_rd_addr];
   end

   // Destination addresses
   always_ff @(posedge clock) begin
      if (dest_wr_en) begin
         dest_mem[dest_wr_addr] <= dest_wr_data;
      end
      dest_rd_data <= dest_mem[dest_rd_addr];
   end

endmodule

// ===== rtl/core/rdrp_exec.sv =====
// ----------------------------------------------------------------------------
// Receive descriptor ring producer - execute logic
// Validates a request against the read entry data, picks the copy length,
// packs descriptor words and decides the store updates.
// ----------------------------------------------------------------------------
module rdrp_exec #(
   parameter int ENTRY_COUNT  = rdrp_pkg::ENTRY_COUNT_DEF,
   parameter int COPY_LIMIT   = rdrp_pkg::COPY_LIMIT_DEF,
   parameter int PACKET_LIMIT = rdrp_pkg::PACKET_LIMIT_DEF,
   localparam int IDX_W       = $clog2(ENTRY_COUNT)
) (
   input  rdrp_pkg::req_type           req,
   input  logic [IDX_W-1:0]            prod,
   input  logic [IDX_W-1:0]            prod_next,
   input  logic                        guard_occupied,
   input  logic [rdrp_pkg::ADDR_W-1:0] prod_dest,
   output rdrp_pkg::rsp_type           rsp,
   output rdrp_pkg::exec_ctl_type      ctl
);
   import rdrp_pkg::*;

   logic             bad_delivery;
   logic             bad_copy;
   logic             oversize;
   logic [LEN_W-1:0] frag_clamped;
   logic [LEN_W-1:0] copy_len;
   logic             index_ok;

   // Delivery checks
   assign bad_delivery = (req.source_address == '0) || (req.source_address[1:0] != 2'b00) ||
                         (req.pkt_len == '0) ||
                         (req.pkt_len > LEN_W'(PACKET_LIMIT)) ||
                         (req.frag_len > LEN_W'(PACKET_LIMIT));

   // Copy length: total, or fragment clamped to the copy limit when oversize
   assign oversize     = req.pkt_len > LEN_W'(COPY_LIMIT);
   assign frag_clamped = (req.frag_len > LEN_W'(COPY_LIMIT)) ?
                         LEN_W'(COPY_LIMIT) : req.frag_len;
   assign copy_len     = oversize ? frag_clamped : req.pkt_len;

   assign bad_copy = (copy_len == '0) || (prod_dest == '0) || (prod_dest[1:0] != 2'b00);

   // Refill indexes beyond the ring are dropped
   assign index_ok = {22'd0, req.entry_index} < 32'(ENTRY_COUNT);

   // Result and store updates
   always_comb begin
      rsp               = '0;
      rsp.status        = STATUS_OK;
      rsp.next_producer = ENTRY_W'(prod);
      ctl               = '0;
      priority if (req.cmd == CMD_REFILL) begin
         ctl.refill_wr = index_ok;
      end else if (bad_delivery) begin
         rsp.status = STATUS_RANGE;
      end else if (guard_occupied) begin
         rsp.status = STATUS_FULL;
      end else if (bad_copy) begin
         rsp.status = STATUS_RANGE;
      end else begin
         ctl.commit         = 1'b1;
         rsp.copy_valid     = 1'b1;
         rsp.copy_source    = req.source_address;
         rsp.copy_dest      = prod_dest;
         rsp.copy_bytes     = copy_len;
         rsp.oversize_used  = oversize;
         rsp.written_entry  = ENTRY_W'(prod);
         rsp.control_word   = {2'b00, req.flag_bit, req.pkt_len,
                               req.frag_len, 1'b1};
         rsp.metadata_word  = {req.rx_flags, 5'd0, req.route, req.flow_tag};
         rsp.desc_word      = req.pkt_word;
         rsp.next_producer  = ENTRY_W'(prod_next);
      end
   end

endmodule

// ===== rtl/core/rx_descriptor_ring_producer_core.sv =====
// ----------------------------------------------------------------------------
// Receive descriptor ring producer - top level
// Refills ring entries and enqueues deliveries into a host-shared ring.
//
//   Channel   Ports                     Handshake
//   request   start, busy, req_data     taken when start & !busy
//   response  rsp_strobe, rsp_data      one cycle per result, no backpressure
//
// An accepted request reads the ring stores in its accept cycle and executes
// in the next; busy is high for the execute cycle. The result appears on
// rsp_data the cycle after execute, while the next request may already be
// accepted. After reset a clearing pass zeroes both stores, one entry a
// cycle, with busy high.
// ----------------------------------------------------------------------------
module rx_descriptor_ring_producer_core #(
   parameter int ENTRY_COUNT  = rdrp_pkg::ENTRY_COUNT_DEF,
   parameter int COPY_LIMIT   = rdrp_pkg::COPY_LIMIT_DEF,
   parameter int PACKET_LIMIT = rdrp_pkg::PACKET_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rdrp_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rdrp_pkg::rsp_type rsp_data
);
   import rdrp_pkg::*;

   localparam int IDX_W = $clog2(ENTRY_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] prod_ff, prod_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic [IDX_W-1:0] prod_next;
   logic [IDX_W-1:0] guard_idx;
   logic             accept;
   logic             clearing;
   logic             executing;
   logic             occ_wr_en, occ_wr_data, occ_rd_data;
   logic [IDX_W-1:0] occ_wr_addr;
   logic             dest_wr_en;
   logic [IDX_W-1:0] dest_wr_addr;
   logic [ADDR_W-1:0] dest_wr_data, dest_rd_data;
   rsp_type          exec_rsp;
   exec_ctl_type     exec_ctl;

   // Ring arithmetic with wrap
   assign prod_next = (prod_ff == LAST_IDX) ? '0 : prod_ff + 1'b1;
   assign guard_idx = (prod_next == LAST_IDX) ? '0 : prod_next + 1'b1;

   assign accept = start && !busy;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State outputs
   always_comb begin
      busy      = 1'b1;
      clearing  = 1'b0;
      executing = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clearing  = 1'b1;
         ST_IDLE:  busy      = 1'b0;
         ST_EXEC:  executing = 1'b1;
         default:  busy      = 1'b1;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         prod_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         prod_ff   <= prod_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign clr_in    = clearing ? clr_ff + 1'b1 : clr_ff;
   assign prod_in   = (executing && exec_ctl.commit) ? prod_next : prod_ff;
   assign req_in    = accept ? req_data : req_ff;
   assign rsp_in    = executing ? exec_rsp : rsp_ff;
   assign strobe_in = executing;

   // Store write selection
   always_comb begin
      occ_wr_en    = 1'b0;
      occ_wr_addr  = prod_ff;
      occ_wr_data  = 1'b0;
      dest_wr_en   = 1'b0;
      dest_wr_addr = IDX_W'(req_ff.entry_index);
      dest_wr_data = req_ff.dest_address;
      priority if (clearing) begin
         occ_wr_en    = 1'b1;
         occ_wr_addr  = clr_ff;
         dest_wr_en   = 1'b1;
         dest_wr_addr = clr_ff;
         dest_wr_data = '0;
      end else if (executing && exec_ctl.refill_wr) begin
         occ_wr_en   = 1'b1;
         occ_wr_addr = IDX_W'(req_ff.entry_index);
         dest_wr_en  = 1'b1;
      end else if (executing && exec_ctl.commit) begin
         occ_wr_en   = 1'b1;
         occ_wr_data = 1'b1;
      end
   end

   rdrp_ring_mem #(
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_mem (
      .clock        (clock),
      .occ_wr_en    (occ_wr_en),
      .occ_wr_addr  (occ_wr_addr),
      .occ_wr_data  (occ_wr_data),
      .occ_rd_addr  (guard_idx),
      .occ_rd_data  (occ_rd_data),
      .dest_wr_en   (dest_wr_en),
      .dest_wr_addr (dest_wr_addr),
      .dest_wr_data (dest_wr_data),
      .dest_rd_addr (prod_ff),
      .dest_rd_data (dest_rd_data)
   );

   rdrp_exec #(
      .ENTRY_COUNT  (ENTRY_COUNT),
      .COPY_LIMIT   (COPY_LIMIT),
      .PACKET_LIMIT (PACKET_LIMIT)
   ) u_exec (
      .req            (req_ff),
      .prod           (prod_ff),
      .prod_next      (prod_next),
      .guard_occupied (occ_rd_data),
      .prod_dest      (dest_rd_data),
      .rsp            (exec_rsp),
      .ctl            (exec_ctl)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Receive descriptor ring producer - testbench
// Drives refill and enqueue requests through the start/busy port. A clocked
// monitor updates a shadow ring on every accepted request and compares each
// strobed result, field by field, against the oldest predicted descriptor.
// The random part keeps the ring fed by host refills, with malformed
// deliveries and unusable buffers mixed in.
// ----------------------------------------------------------------------------
module testbench;
   import rdrp_pkg::*;

   localparam int RING_SIZE     = ENTRY_COUNT_DEF;
   localparam int COPY_MAX      = COPY_LIMIT_DEF;
   localparam int PACKET_MAX    = PACKET_LIMIT_DEF;
   localparam int RANDOM_ITEMS  = 1130;
   localparam int PHASE_ITEMS   = 160;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Request and expectation stores
   req_type pending_requests[$];
   rsp_type expected_descriptors[$];
   rsp_type want_desc;

   // Shadow of the ring as the block should hold it
   bit          ring_occupied [RING_SIZE];
   logic [31:0] ring_dest [RING_SIZE] = '{default: 32'h0};
   int          ring_head = 0;

   int   pushed_count   = 0;
   int   taken_count    = 0;
   int   error_count    = 0;
   int   cycle_count    = 0;
   int   idle_pct       = 0;
   logic req_taken      = 1'b0;

   rx_descriptor_ring_producer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic int ring_step(int i);
      return (i == RING_SIZE - 1) ? 0 : i + 1;
   endfunction

   function automatic bit dest_usable(int i);
      return ring_dest[i] != 32'h0 && ring_dest[i][1:0] == 2'b00;
   endfunction

   // Work out the descriptor result of one accepted request
   task automatic predict_descriptor(input req_type r);
      rsp_type     res;
      logic [13:0] nbytes;
      bit          over;
      int          head;
      res = '0;
      res.status = STATUS_OK;
      head = ring_head;
      res.next_producer = 10'(head);
      if (r.cmd == CMD_REFILL) begin
         if (int'(r.entry_index) < RING_SIZE) begin
            ring_occupied[r.entry_index] = 1'b0;
            ring_dest[r.entry_index] = r.dest_address;
         end
      end else if (r.source_address == 32'h0 || r.source_address[1:0] != 2'b00 ||
                   r.pkt_len == 0 || int'(r.pkt_len) > PACKET_MAX ||
                   int'(r.frag_len) > PACKET_MAX) begin
         res.status = STATUS_RANGE;
      end else if (ring_occupied[ring_step(ring_step(head))]) begin
         res.status = STATUS_FULL;
      end else begin
         over = int'(r.pkt_len) > COPY_MAX;
         nbytes = r.pkt_len;
         if (over) begin
            nbytes = (int'(r.frag_len) > COPY_MAX) ? 14'(COPY_MAX) : r.frag_len;
         end
         if (nbytes == 0 || !dest_usable(head)) begin
            res.status = STATUS_RANGE;
         end else begin
            ring_occupied[head] = 1'b1;
            ring_head = ring_step(head);
            res.copy_valid = 1'b1;
            res.copy_source = r.source_address;
            res.copy_dest = ring_dest[head];
            res.copy_bytes = nbytes;
            res.oversize_used = over;
            res.written_entry = 10'(head);
            res.control_word = (32'(r.pkt_len) << 15) | (32'(r.frag_len) << 1) |
                               (32'(r.flag_bit) << 29) | 32'd1;
            res.metadata_word = (32'(r.rx_flags) << 26) | (32'(r.route) << 16) |
                                32'(r.flow_tag);
            res.desc_word = r.pkt_word;
            res.next_producer = 10'(ring_head);
         end
      end
      expected_descriptors.push_back(res);
   endtask

   task automatic report_error(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR @%0d: %s", cycle_count, what);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s got %h expected %h", name, got, want));
      end
   endtask

   // Random content for every field; a well-formed delivery by default
   function automatic req_type random_delivery();
      req_type r;
      int      pick;
      r.cmd = CMD_ENQUEUE;
      r.entry_index = 10'($urandom);
      r.dest_address = $urandom;
      r.source_address = $urandom & 32'hFFFF_FFFC;
      if (r.source_address == 32'h0) begin
         r.source_address = 32'h4;
      end
      pick = $urandom_range(19);
      if (pick < 13) begin
         r.pkt_len = 14'($urandom_range(COPY_MAX, 1));
      end else if (pick < 18) begin
         r.pkt_len = 14'($urandom_range(PACKET_MAX, COPY_MAX + 1));
      end else begin
         r.pkt_len = (pick == 18) ? 14'(COPY_MAX) : 14'(PACKET_MAX);
      end
      r.frag_len = $urandom_range(1) ? 14'($urandom_range(COPY_MAX)) : 14'($urandom);
      r.flag_bit = 1'($urandom);
      r.rx_flags = 6'($urandom);
      r.route = 5'($urandom);
      r.flow_tag = 16'($urandom);
      r.pkt_word = $urandom;
      return r;
   endfunction

   function automatic req_type make_delivery(input logic [31:0] src, input logic [13:0] total,
                                             input logic [13:0] frag);
      req_type r;
      r = random_delivery();
      r.source_address = src;
      r.pkt_len = total;
      r.frag_len = frag;
      return r;
   endfunction

   function automatic req_type make_refill(input logic [9:0] entry, input logic [31:0] dest);
      req_type r;
      r = random_delivery();
      r.cmd = CMD_REFILL;
      r.entry_index = entry;
      r.dest_address = dest;
      return r;
   endfunction

   // Host buffer address, now and then unusable
   function automatic logic [31:0] host_buffer();
      logic [31:0] d;
      d = $urandom & 32'hFFFF_FFFC;
      if (d == 32'h0) begin
         d = 32'h4;
      end
      if ($urandom_range(49) == 0) begin
         d = $urandom_range(1) ? 32'h0 : (d | 32'(1 + $urandom_range(2)));
      end
      return d;
   endfunction

   task automatic push_item(input req_type r);
      pending_requests.push_back(r);
      pushed_count++;
   endtask

   // Hold off until every request is taken and every result is back
   task automatic drain_results();
      wait (taken_count == pushed_count);
      while (expected_descriptors.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: new request at the falling edge, held until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= pending_requests.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: accepted requests feed the shadow ring, results are checked
   always @(posedge clock) begin
      req_taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         predict_descriptor(req_data);
         taken_count++;
      end
      if (!reset && rsp_strobe) begin
         if (expected_descriptors.size() == 0) begin
            report_error("result with nothing expected");
         end else begin
            want_desc = expected_descriptors.pop_front();
            check_field("status", 32'(rsp_data.status), 32'(want_desc.status));
            check_field("copy_valid", 32'(rsp_data.copy_valid), 32'(want_desc.copy_valid));
            check_field("copy_source", rsp_data.copy_source, want_desc.copy_source);
            check_field("copy_dest", rsp_data.copy_dest, want_desc.copy_dest);
            check_field("copy_bytes", 32'(rsp_data.copy_bytes), 32'(want_desc.copy_bytes));
            check_field("oversize_used", 32'(rsp_data.oversize_used),
                        32'(want_desc.oversize_used));
            check_field("written_entry", 32'(rsp_data.written_entry),
                        32'(want_desc.written_entry));
            check_field("control_word", rsp_data.control_word, want_desc.control_word);
            check_field("metadata_word", rsp_data.metadata_word, want_desc.metadata_word);
            check_field("desc_word", rsp_data.desc_word, want_desc.desc_word);
            check_field("next_producer", 32'(rsp_data.next_producer),
                        32'(want_desc.next_producer));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus
   initial begin
      req_type item;
      int      head;
      int      guard;
      int      roll;
      int      phase;
      int      new_phase;
      int      random_items;
      int      idle_choice [3];
      idle_choice = '{0, 84, 8};
      phase = 0;
      random_items = 0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: refusals on a fresh ring
      push_item(make_delivery(32'h0000_0004, 14'd64, 14'd0));    // producer entry has no buffer
      push_item(make_delivery(32'h0000_0000, 14'd64, 14'd0));    // zero source
      push_item(make_delivery(32'h0000_1002, 14'd64, 14'd0));    // unaligned source
      push_item(make_delivery(32'h0000_1000, 14'd0, 14'd5));     // empty packet
      push_item(make_refill(10'd0, 32'hFFFF_FFFC));
      push_item(make_refill(10'd1, 32'h0000_0004));
      push_item(make_refill(10'd2, 32'h8000_0002));              // unaligned buffer
      // all-ones fields, smallest packet
      item = make_delivery(32'hFFFF_FFFC, 14'd1, 14'h3FFF);
      item.flag_bit = 1'b1;
      item.rx_flags = '1;
      item.route = '1;
      item.flow_tag = '1;
      item.pkt_word = '1;
      push_item(item);
      // all-zero fields, packet exactly at the copy limit
      item = make_delivery(32'h0000_0004, 14'(COPY_MAX), 14'd0);
      item.flag_bit = 1'b0;
      item.rx_flags = '0;
      item.route = '0;
      item.flow_tag = '0;
      item.pkt_word = '0;
      push_item(item);
      push_item(make_delivery(32'h0000_0100, 14'd100, 14'd50));  // unaligned buffer refused
      push_item(make_refill(10'd2, 32'h1234_5678));
      push_item(make_delivery(32'h0000_0200, 14'(COPY_MAX + 1), 14'd0)); // oversize, no fragment
      push_item(make_delivery(32'h0000_0300, 14'h3FFF, 14'h3FFF));       // fragment clamped
      push_item(make_refill(10'd3, 32'hDEAD_BEE0));
      push_item(make_delivery(32'h0000_0400, 14'd9000, 14'(COPY_MAX)));
      push_item(make_refill(10'(RING_SIZE - 1), 32'hFFFF_FFFC));
      push_item(make_refill(10'd4, 32'h0000_0000));               // zero buffer
      push_item(make_delivery(32'h0000_0500, 14'd700, 14'd700));
      push_item(make_refill(10'd4, 32'h0000_4000));
      push_item(make_delivery(32'h0000_0600, 14'd3000, 14'd1));
      drain_results();

      // Random: host keeps the ring fed, with noise and late refills
      while (random_items < RANDOM_ITEMS) begin
         new_phase = (random_items / PHASE_ITEMS) % 3;
         if (new_phase != phase) begin
            drain_results();
            phase = new_phase;
            idle_pct = idle_choice[phase];
         end
         wait (taken_count == pushed_count);
         head = ring_head;
         guard = ring_step(ring_step(head));
         roll = $urandom_range(99);
         if (roll < 6) begin
            push_item(make_refill(10'($urandom), $urandom));
         end else if (roll < 12) begin
            // delivery with a zero or random source address and length
            item = random_delivery();
            item.source_address = (roll < 8) ? 32'h0 : $urandom;
            item.pkt_len = (roll == 11) ? 14'd0 : 14'($urandom);
            push_item(item);
         end else if (!dest_usable(head) && roll >= 20) begin
            push_item(make_refill(10'(head), host_buffer()));
         end else if (ring_occupied[guard] && roll >= 30) begin
            push_item(make_refill(10'(guard), host_buffer()));
         end else begin
            push_item(random_delivery());
         end
         random_items++;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (expected_descriptors.size() != 0) begin
         report_error($sformatf("%0d results never came", expected_descriptors.size()));
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rdrp_pkg.sv
rtl/core/rdrp_ring_mem.sv
rtl/core/rdrp_exec.sv
rtl/core/rx_descriptor_ring_producer_core.sv
verif/testbench.sv
